@@ rtl/core/plas_pkg.sv @@
package plas_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef logic [IW-1:0] idx_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic [CW:0]   cntx_t;

    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_CLEAR   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE  = 2'd2;
    localparam logic [1:0] ACT_PROJECT = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic signed [33:0] HUNDREDTH_Q16 = 34'sd655;
    localparam logic [15:0]        ONE_Q14       = 16'd16384;
    localparam logic [30:0]        SAT31         = 31'h7FFF_FFFF;

    typedef logic [2:0][31:0] pt3_t;
    typedef logic [2:0][15:0] dir3_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] arc_query;
    } in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [30:0]        arc_position;
        logic [30:0]        total_length;
        logic [1:0]         status;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_APP_RD,
        ST_APP_DIV,
        ST_APP_DQ,
        ST_APP_WR,
        ST_NRM_MUL,
        ST_NRM_ACC,
        ST_LEN,
        ST_SQ_WAIT,
        ST_DIV_WAIT,
        ST_SMP_CHK,
        ST_SMP_MUL,
        ST_SMP_ADD,
        ST_PRJ_RD0,
        ST_PRJ_RD1,
        ST_PRJ_SHIFT,
        ST_PRJ_MUL,
        ST_PRJ_ACC,
        ST_PRJ_K,
        ST_PRJ_KQ,
        ST_PRJ_OM,
        ST_PRJ_OA,
        ST_PRJ_CMP,
        ST_PRJ_ARC,
        ST_PRJ_NEXT,
        ST_DONE
    } state_t;

    function automatic logic signed [33:0] sx32(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [33:0] sx16(input logic [15:0] v);
        return {{18{v[15]}}, v};
    endfunction

    function automatic logic [32:0] mag34(input logic signed [33:0] v);
        logic [33:0] n;
        n = -v;
        return v[33] ? n[32:0] : v[32:0];
    endfunction

    function automatic logic signed [33:0] sgn34(input logic [32:0] m, input logic neg);
        logic signed [33:0] p;
        p = $signed({1'b0, m});
        return neg ? -p : p;
    endfunction

    function automatic logic signed [33:0] tshr(input logic signed [33:0] v,
                                                input logic [1:0] s);
        return sgn34(mag34(v) >> s, v[33]);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/plas_store.sv @@
module plas_store (
    input  logic             aclk,
    input  logic             pt_we,
    input  plas_pkg::idx_t   pt_addr,
    input  plas_pkg::pt3_t   pt_wdata,
    input  logic             seg_we,
    input  plas_pkg::idx_t   seg_addr,
    input  logic [31:0]      seg_len,
    input  plas_pkg::dir3_t  seg_dir,
    input  plas_pkg::idx_t   rd_addr,
    output plas_pkg::pt3_t   rd_point,
    output logic [31:0]      rd_len,
    output plas_pkg::dir3_t  rd_dir
);
    import plas_pkg::*;

    pt3_t        pt_mem  [MAX_POINTS];
    logic [31:0] len_mem [MAX_POINTS];
    dir3_t       dir_mem [MAX_POINTS];

    pt3_t        rd_point_reg;
    logic [31:0] rd_len_reg;
    dir3_t       rd_dir_reg;

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_addr] <= pt_wdata;
        end
        if (seg_we) begin
            len_mem[seg_addr] <= seg_len;
            dir_mem[seg_addr] <= seg_dir;
        end
        rd_point_reg <= pt_mem[rd_addr];
        rd_len_reg   <= len_mem[rd_addr];
        rd_dir_reg   <= dir_mem[rd_addr];
    end

    assign rd_point = rd_point_reg;
    assign rd_len   = rd_len_reg;
    assign rd_dir   = rd_dir_reg;

endmodule

@@ rtl/core/plas_sqrt.sv @@
module plas_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb begin
        rem_sh = {rem_reg, x_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg  <= 5'd31;
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            x_reg   <= {x_reg[61:0], 2'b00};
            if (ge) begin
                rem_reg  <= diff[33:0];
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/plas_div.sv @@
module plas_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] rem0,
    input  logic [31:0] num,
    input  logic [63:0] den,
    input  logic [4:0]  steps,
    output logic        done,
    output logic [31:0] quot
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] r_reg;
    logic [31:0] n_reg;
    logic [63:0] d_reg;
    logic [31:0] q_reg;

    logic [64:0] r2;
    logic [64:0] rdiff;
    logic        ge;

    always_comb begin
        r2    = {r_reg, n_reg[31]};
        rdiff = r2 - {1'b0, d_reg};
        ge    = r2 >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= steps - 5'd1;
            r_reg   <= rem0;
            n_reg   <= num;
            d_reg   <= den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            n_reg   <= {n_reg[30:0], 1'b0};
            r_reg   <= ge ? rdiff[63:0] : r2[63:0];
            q_reg   <= {q_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ rtl/core/polyline_arc_length_sampler.sv @@
// Polyline arc-length sampler.
// Input channel s_valid/s_ready/s_data carries one command per transfer:
// append a point, clear the path, sample at an arc length, or project a
// position onto the path. Each command yields exactly one result transfer
// on m_valid/m_ready/m_data.
// One command is processed at a time; s_ready is high only when idle.
// Clear, an append to an empty or full path and a query on a path with no
// segment take no multiply, square root or divide. An append takes a square
// root for the segment length and a divide for each direction component,
// with no divides when the new point repeats the last one; a sample walks the
// segments up to the query; a project visits every segment, divides when
// the position falls inside it and takes a square root when a new nearest
// segment is found. Multiplies, square roots and divides go through one
// 33x33 multiplier, one bit-serial square root and one bit-serial divider.
// A finished result sits in the output register; the next command is
// taken while it waits, and a second result waits until the first is
// taken. Results hold steady while m_ready is low.
// Reset (aresetn low, synchronous) empties the path and drops any pending
// result; stored points need no clearing.
module polyline_arc_length_sampler (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  plas_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output plas_pkg::out_t m_data
);
    import plas_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    cnt_t   cnt_reg, cnt_next;
    logic [31:0] sum_reg, sum_next;
    in_t    in_reg, in_next;
    idx_t   i_reg, i_next;
    logic [1:0] c_reg, c_next;
    logic [2:0] t_reg, t_next;
    logic   do_len_reg, do_len_next;

    logic signed [33:0] nv_reg [3];
    logic signed [33:0] nv_next [3];
    logic [65:0] nacc_reg, nacc_next;
    logic [31:0] len_reg, len_next;
    logic [65:0] prod_reg, prod_next;

    logic signed [33:0] remain_reg, remain_next;
    pt3_t   p0_reg, p0_next;
    logic signed [33:0] dv_reg [3];
    logic signed [33:0] dv_next [3];
    logic signed [33:0] wv_reg [3];
    logic signed [33:0] wv_next [3];
    logic signed [33:0] ds_reg [3];
    logic signed [33:0] ds_next [3];
    logic signed [33:0] ws_reg [3];
    logic signed [33:0] ws_next [3];
    logic signed [33:0] off_reg [3];
    logic signed [33:0] off_next [3];
    logic signed [33:0] lp_reg [3];
    logic signed [33:0] lp_next [3];
    logic [63:0] dd_reg, dd_next;
    logic signed [63:0] wd_reg, wd_next;
    logic [30:0] k_reg, k_next;
    logic [65:0] best_reg, best_next;
    logic   found_reg, found_next;
    logic [39:0] prefix_reg, prefix_next;
    logic [39:0] arc_reg, arc_next;
    logic [31:0] seglen_reg, seglen_next;
    dir3_t  segdir_reg, segdir_next;

    pt3_t   res_pt_reg, res_pt_next;
    dir3_t  res_dir_reg, res_dir_next;
    logic [30:0] res_arc_reg, res_arc_next;
    logic [1:0]  res_stat_reg, res_stat_next;

    logic   m_valid_reg, m_valid_next;
    out_t   m_data_reg, m_data_next;

    logic signed [33:0] qs [3];
    logic [32:0] ma, mb;
    logic [1:0]  tc;

    logic        pt_we, seg_we;
    idx_t        pt_addr, seg_addr, rd_addr;
    pt3_t        rd_point;
    logic [31:0] rd_len;
    dir3_t       rd_dir;

    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic        dv_start, dv_done;
    logic [63:0] dv_rem0, dv_den;
    logic [31:0] dv_num, dv_quot;
    logic [4:0]  dv_steps;

    logic [47:0] app_n;
    logic [15:0] dq_m;
    logic [32:0] sum_add;
    logic [32:0] mmax;
    logic [1:0]  sh;
    logic [32:0] rnd_m;
    logic signed [33:0] tmp_v;
    logic signed [33:0] tmp_e;
    cntx_t       i_ext, cnt_ext;

    plas_store u_store (
        .aclk     (aclk),
        .pt_we    (pt_we),
        .pt_addr  (pt_addr),
        .pt_wdata ({in_reg.pos_z, in_reg.pos_y, in_reg.pos_x}),
        .seg_we   (seg_we),
        .seg_addr (seg_addr),
        .seg_len  (len_reg),
        .seg_dir  (res_dir_reg),
        .rd_addr  (rd_addr),
        .rd_point (rd_point),
        .rd_len   (rd_len),
        .rd_dir   (rd_dir)
    );

    plas_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (nacc_reg[63:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    plas_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .rem0    (dv_rem0),
        .num     (dv_num),
        .den     (dv_den),
        .steps   (dv_steps),
        .done    (dv_done),
        .quot    (dv_quot)
    );

    assign qs[0] = sx32(in_reg.pos_x);
    assign qs[1] = sx32(in_reg.pos_y);
    assign qs[2] = sx32(in_reg.pos_z);

    assign i_ext   = cntx_t'(i_reg);
    assign cnt_ext = cntx_t'(cnt_reg);
    assign tc      = (t_reg < 3'd3) ? t_reg[1:0] : 2'(t_reg - 3'd3);

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ST_NRM_MUL: begin
                ma = mag34(nv_reg[c_reg]);
                mb = mag34(nv_reg[c_reg]);
            end
            ST_SMP_MUL: begin
                ma = mag34(sx16(res_dir_reg[c_reg]));
                mb = mag34(remain_reg);
            end
            ST_PRJ_MUL: begin
                ma = (t_reg < 3'd3) ? mag34(ds_reg[tc]) : mag34(ws_reg[tc]);
                mb = mag34(ds_reg[tc]);
            end
            ST_PRJ_OM: begin
                ma = mag34(dv_reg[c_reg]);
                mb = {2'b00, k_reg};
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod_next = 66'(ma) * 66'(mb);
    end

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        in_next       = in_reg;
        i_next        = i_reg;
        c_next        = c_reg;
        t_next        = t_reg;
        do_len_next   = do_len_reg;
        nv_next       = nv_reg;
        nacc_next     = nacc_reg;
        len_next      = len_reg;
        remain_next   = remain_reg;
        p0_next       = p0_reg;
        dv_next       = dv_reg;
        wv_next       = wv_reg;
        ds_next       = ds_reg;
        ws_next       = ws_reg;
        off_next      = off_reg;
        lp_next       = lp_reg;
        dd_next       = dd_reg;
        wd_next       = wd_reg;
        k_next        = k_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        prefix_next   = prefix_reg;
        arc_next      = arc_reg;
        seglen_next   = seglen_reg;
        segdir_next   = segdir_reg;
        res_pt_next   = res_pt_reg;
        res_dir_next  = res_dir_reg;
        res_arc_next  = res_arc_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        pt_we    = 1'b0;
        seg_we   = 1'b0;
        pt_addr  = cnt_reg[IW-1:0];
        seg_addr = idx_t'(cnt_reg[IW-1:0] - 1'b1);
        rd_addr  = i_reg;
        sq_start = 1'b0;
        dv_start = 1'b0;
        dv_rem0  = '0;
        dv_num   = '0;
        dv_den   = '0;
        dv_steps = 5'd1;

        app_n   = ({15'b0, mag34(nv_reg[c_reg])} << 14) + {17'b0, len_reg[31:1]};
        dq_m    = (dv_quot > 32'(ONE_Q14)) ? ONE_Q14 : dv_quot[15:0];
        sum_add = {1'b0, sum_reg} + {1'b0, len_reg};
        rnd_m   = '0;
        tmp_v   = '0;
        tmp_e   = '0;

        mmax = mag34(dv_reg[0]);
        for (int j = 0; j < 3; j++) begin
            if (mag34(dv_reg[j]) > mmax) mmax = mag34(dv_reg[j]);
            if (mag34(wv_reg[j]) > mmax) mmax = mag34(wv_reg[j]);
        end
        if (mmax[32])      sh = 2'd3;
        else if (mmax[31]) sh = 2'd2;
        else if (mmax[30]) sh = 2'd1;
        else               sh = 2'd0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_pt_next   = '0;
                res_dir_next  = '0;
                res_arc_next  = '0;
                res_stat_next = STAT_OK;
                state_next    = ST_DONE;
                case (in_reg.action)
                    ACT_APPEND: begin
                        if (cnt_reg == cnt_t'(MAX_POINTS)) begin
                            res_stat_next = STAT_FULL;
                        end else begin
                            pt_we       = 1'b1;
                            res_pt_next = {in_reg.pos_z, in_reg.pos_y, in_reg.pos_x};
                            if (cnt_reg == '0) begin
                                cnt_next = cnt_reg + 1'b1;
                            end else begin
                                rd_addr    = idx_t'(cnt_reg[IW-1:0] - 1'b1);
                                state_next = ST_APP_RD;
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        cnt_next = '0;
                        sum_next = '0;
                    end
                    default: begin
                        if (cnt_reg < cnt_t'(2)) begin
                            res_stat_next = STAT_EMPTY;
                        end else begin
                            i_next  = '0;
                            rd_addr = '0;
                            if (in_reg.action == ACT_SAMPLE) begin
                                remain_next = sx32(in_reg.arc_query);
                                if (sx32(in_reg.arc_query) > $signed({2'b00, sum_reg})) begin
                                    remain_next = $signed({2'b00, sum_reg}) - HUNDREDTH_Q16;
                                end
                                state_next = ST_SMP_CHK;
                            end else begin
                                found_next  = 1'b0;
                                prefix_next = '0;
                                arc_next    = '0;
                                state_next  = ST_PRJ_RD0;
                            end
                        end
                    end
                endcase
            end
            ST_APP_RD: begin
                for (int j = 0; j < 3; j++) begin
                    nv_next[j] = qs[j] - sx32(rd_point[j]);
                end
                c_next      = '0;
                nacc_next   = '0;
                do_len_next = 1'b1;
                ret_next    = ST_APP_DIV;
                state_next  = ST_NRM_MUL;
            end
            ST_APP_DIV: begin
                if (len_reg == '0) begin
                    res_dir_next[c_reg] = '0;
                    if (c_reg == 2'd2) begin
                        state_next = ST_APP_WR;
                    end else begin
                        c_next = c_reg + 2'd1;
                    end
                end else begin
                    dv_start   = 1'b1;
                    dv_rem0    = {32'b0, app_n[47:16]};
                    dv_num     = {app_n[15:0], 16'b0};
                    dv_den     = {32'b0, len_reg};
                    dv_steps   = 5'd16;
                    ret_next   = ST_APP_DQ;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_APP_DQ: begin
                res_dir_next[c_reg] = nv_reg[c_reg][33] ? 16'(-dq_m) : dq_m;
                if (c_reg == 2'd2) begin
                    state_next = ST_APP_WR;
                end else begin
                    c_next     = c_reg + 2'd1;
                    state_next = ST_APP_DIV;
                end
            end
            ST_APP_WR: begin
                seg_we     = 1'b1;
                sum_next   = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_NRM_MUL: begin
                state_next = ST_NRM_ACC;
            end
            ST_NRM_ACC: begin
                nacc_next = nacc_reg + {2'b00, prod_reg[63:0]};
                if (c_reg == 2'd2) begin
                    c_next     = '0;
                    state_next = do_len_reg ? ST_LEN : ret_reg;
                end else begin
                    c_next     = c_reg + 2'd1;
                    state_next = ST_NRM_MUL;
                end
            end
            ST_LEN: begin
                if (nacc_reg[65:64] != 2'b00) begin
                    len_next   = 32'hFFFF_FFFF;
                    state_next = ret_reg;
                end else begin
                    sq_start   = 1'b1;
                    state_next = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT: begin
                if (sq_done) begin
                    len_next   = sq_root;
                    state_next = ret_reg;
                end
            end
            ST_DIV_WAIT: begin
                if (dv_done) state_next = ret_reg;
            end
            ST_SMP_CHK: begin
                if (remain_reg <= $signed({2'b00, rd_len})) begin
                    p0_next      = rd_point;
                    res_dir_next = rd_dir;
                    c_next       = '0;
                    state_next   = ST_SMP_MUL;
                end else begin
                    remain_next = remain_reg - $signed({2'b00, rd_len});
                    if (i_ext + cntx_t'(2) >= cnt_ext) begin
                        state_next = ST_DONE;
                    end else begin
                        i_next  = i_reg + 1'b1;
                        rd_addr = i_reg + 1'b1;
                    end
                end
            end
            ST_SMP_MUL: begin
                state_next = ST_SMP_ADD;
            end
            ST_SMP_ADD: begin
                rnd_m = 33'((prod_reg[63:0] + 64'd8192) >> 14);
                tmp_v = sx32(p0_reg[c_reg])
                      + sgn34(rnd_m, res_dir_reg[c_reg][15] ^ remain_reg[33]);
                res_pt_next[c_reg] = sat32(tmp_v);
                if (c_reg == 2'd2) begin
                    state_next = ST_DONE;
                end else begin
                    c_next     = c_reg + 2'd1;
                    state_next = ST_SMP_MUL;
                end
            end
            ST_PRJ_RD0: begin
                p0_next     = rd_point;
                seglen_next = rd_len;
                segdir_next = rd_dir;
                rd_addr     = i_reg + 1'b1;
                state_next  = ST_PRJ_RD1;
            end
            ST_PRJ_RD1: begin
                for (int j = 0; j < 3; j++) begin
                    dv_next[j] = sx32(rd_point[j]) - sx32(p0_reg[j]);
                    wv_next[j] = qs[j] - sx32(p0_reg[j]);
                end
                state_next = ST_PRJ_SHIFT;
            end
            ST_PRJ_SHIFT: begin
                for (int j = 0; j < 3; j++) begin
                    ds_next[j] = tshr(dv_reg[j], sh);
                    ws_next[j] = tshr(wv_reg[j], sh);
                end
                dd_next    = '0;
                wd_next    = '0;
                t_next     = '0;
                state_next = ST_PRJ_MUL;
            end
            ST_PRJ_MUL: begin
                state_next = ST_PRJ_ACC;
            end
            ST_PRJ_ACC: begin
                if (t_reg < 3'd3) begin
                    dd_next = dd_reg + prod_reg[63:0];
                end else if (ws_reg[tc][33] ^ ds_reg[tc][33]) begin
                    wd_next = wd_reg - $signed(prod_reg[63:0]);
                end else begin
                    wd_next = wd_reg + $signed(prod_reg[63:0]);
                end
                if (t_reg == 3'd5) begin
                    state_next = ST_PRJ_K;
                end else begin
                    t_next     = t_reg + 3'd1;
                    state_next = ST_PRJ_MUL;
                end
            end
            ST_PRJ_K: begin
                c_next     = '0;
                k_next     = '0;
                state_next = ST_PRJ_OM;
                if (dd_reg != '0 && !wd_reg[63] && wd_reg != '0) begin
                    if ($unsigned(wd_reg) >= dd_reg) begin
                        k_next = 31'h4000_0000;
                    end else begin
                        dv_start   = 1'b1;
                        dv_rem0    = wd_reg;
                        dv_num     = '0;
                        dv_den     = dd_reg;
                        dv_steps   = 5'd30;
                        ret_next   = ST_PRJ_KQ;
                        state_next = ST_DIV_WAIT;
                    end
                end
            end
            ST_PRJ_KQ: begin
                k_next     = dv_quot[30:0];
                c_next     = '0;
                state_next = ST_PRJ_OM;
            end
            ST_PRJ_OM: begin
                state_next = ST_PRJ_OA;
            end
            ST_PRJ_OA: begin
                rnd_m = 33'((prod_reg[63:0] + 64'd536870912) >> 30);
                tmp_v = sgn34(rnd_m, dv_reg[c_reg][33]);
                tmp_e = sx32(p0_reg[c_reg]) + tmp_v;
                off_next[c_reg] = tmp_v;
                lp_next[c_reg]  = tmp_e;
                nv_next[c_reg]  = tmp_e - qs[c_reg];
                if (c_reg == 2'd2) begin
                    c_next      = '0;
                    nacc_next   = '0;
                    do_len_next = 1'b0;
                    ret_next    = ST_PRJ_CMP;
                    state_next  = ST_NRM_MUL;
                end else begin
                    c_next     = c_reg + 2'd1;
                    state_next = ST_PRJ_OM;
                end
            end
            ST_PRJ_CMP: begin
                if (!found_reg || nacc_reg < best_reg) begin
                    found_next   = 1'b1;
                    best_next    = nacc_reg;
                    for (int j = 0; j < 3; j++) begin
                        res_pt_next[j] = sat32(lp_reg[j]);
                    end
                    res_dir_next = segdir_reg;
                    nv_next      = off_reg;
                    nacc_next    = '0;
                    c_next       = '0;
                    do_len_next  = 1'b1;
                    ret_next     = ST_PRJ_ARC;
                    state_next   = ST_NRM_MUL;
                end else begin
                    state_next = ST_PRJ_NEXT;
                end
            end
            ST_PRJ_ARC: begin
                arc_next   = prefix_reg + {8'b0, len_reg};
                state_next = ST_PRJ_NEXT;
            end
            ST_PRJ_NEXT: begin
                prefix_next = prefix_reg + {8'b0, seglen_reg};
                if (i_ext + cntx_t'(2) < cnt_ext) begin
                    i_next     = i_reg + 1'b1;
                    rd_addr    = i_reg + 1'b1;
                    state_next = ST_PRJ_RD0;
                end else begin
                    res_arc_next = (arc_reg > 40'(SAT31)) ? SAT31 : arc_reg[30:0];
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.point_x       = res_pt_reg[0];
                    m_data_next.point_y       = res_pt_reg[1];
                    m_data_next.point_z       = res_pt_reg[2];
                    m_data_next.dir_x         = res_dir_reg[0];
                    m_data_next.dir_y         = res_dir_reg[1];
                    m_data_next.dir_z         = res_dir_reg[2];
                    m_data_next.arc_position  = res_arc_reg;
                    m_data_next.total_length  = sum_reg[31] ? SAT31 : sum_reg[30:0];
                    m_data_next.status        = res_stat_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg      <= ret_next;
        in_reg       <= in_next;
        i_reg        <= i_next;
        c_reg        <= c_next;
        t_reg        <= t_next;
        do_len_reg   <= do_len_next;
        nv_reg       <= nv_next;
        nacc_reg     <= nacc_next;
        len_reg      <= len_next;
        prod_reg     <= prod_next;
        remain_reg   <= remain_next;
        p0_reg       <= p0_next;
        dv_reg       <= dv_next;
        wv_reg       <= wv_next;
        ds_reg       <= ds_next;
        ws_reg       <= ws_next;
        off_reg      <= off_next;
        lp_reg       <= lp_next;
        dd_reg       <= dd_next;
        wd_reg       <= wd_next;
        k_reg        <= k_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        prefix_reg   <= prefix_next;
        arc_reg      <= arc_next;
        seglen_reg   <= seglen_next;
        segdir_reg   <= segdir_next;
        res_pt_reg   <= res_pt_next;
        res_dir_reg  <= res_dir_next;
        res_arc_reg  <= res_arc_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/plas_checker.sv @@
module plas_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input plas_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input plas_pkg::out_t m_data
);
    import plas_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result transfer changed");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STAT_OK || m_data.status == STAT_EMPTY
                 || m_data.status == STAT_FULL)
        else $error("bad status code");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.point_x == 0
            && m_data.dir_x == 0 && m_data.dir_y == 0 && m_data.arc_position == 0)
        else $error("nonzero fields on error result");

    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.dir_x <= 16'sd16384 && m_data.dir_x >= -16'sd16384
                 && m_data.dir_y <= 16'sd16384 && m_data.dir_y >= -16'sd16384)
        else $error("direction out of range");

endmodule

bind polyline_arc_length_sampler plas_checker u_plas_checker (.*);
